### rtl/hyq_pkg.sv
// Shared types, widths and the binary16 decode function for the pixel quantizer.
`timescale 1ns / 1ps

package hyq_pkg;

	localparam int HALF_W   = 16;                // binary16 pattern
	localparam int MAG_W    = 41;                // signed decoded sample, units of 2^-24
	localparam int SUM_W    = 44;                // signed sum of four samples
	localparam int Q_W      = 42;                // positive mean, units of 2^-26
	localparam int QLO_W    = Q_W / 2;           // low half of the mean for the split multiply
	localparam int QHI_W    = Q_W - QLO_W;
	localparam int SCALE_W  = 24;                // unsigned Q8.16
	localparam int PPLO_W   = QLO_W + SCALE_W;
	localparam int PPHI_W   = QHI_W + SCALE_W;
	localparam int PROD_W   = Q_W + SCALE_W;     // full product, units of 2^-42
	localparam int FRAC_W   = 42;                // fraction bits of the product
	localparam int INT_W    = PROD_W - FRAC_W;
	localparam int PIX_W    = 8;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'hFF0000;
	localparam logic [APB_AW-3:0]  REG_SCALE   = '0;   // register index of scale_q16

	typedef enum logic [1:0] {
		HC_FIN  = 2'd0,
		HC_PINF = 2'd1,
		HC_NINF = 2'd2,
		HC_NAN  = 2'd3
	} half_cls_t;

	typedef enum logic [1:0] {
		RC_ZERO = 2'd0,
		RC_SAT  = 2'd1,
		RC_CALC = 2'd2
	} res_cls_t;

	typedef struct packed {
		half_cls_t               cls;
		logic signed [MAG_W-1:0] mag;
	} half_dec_t;

	function automatic half_dec_t decode_half(input logic [HALF_W-1:0] h);
		half_dec_t       d;
		logic [4:0]      e;
		logic [9:0]      m;
		logic [MAG_W-1:0] u;
		e = h[14:10];
		m = h[9:0];
		u = '0;
		d.cls = HC_FIN;
		d.mag = '0;
		if (e == 5'd31) begin
			if (m != 10'd0)
				d.cls = HC_NAN;
			else if (h[15])
				d.cls = HC_NINF;
			else
				d.cls = HC_PINF;
		end else begin
			if (e == 5'd0)
				u = MAG_W'(m);
			else
				u = MAG_W'({1'b1, m}) << (e - 5'd1);
			d.mag = h[15] ? -$signed(u) : $signed(u);
		end
		return d;
	endfunction

endpackage

### rtl/hyq_cfg.sv
// APB register file holding the scale factor.
`timescale 1ns / 1ps

module hyq_cfg import hyq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	output logic [SCALE_W-1:0] scale
);

	logic [SCALE_W-1:0] scale_q;
	logic [APB_AW-3:0]  reg_idx;

	assign reg_idx = paddr[APB_AW-1:2];
	assign pready  = 1'b1;
	assign scale   = scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_SCALE) begin
			scale_q <= pwdata[SCALE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_SCALE)
			prdata = APB_DW'(scale_q);
	end

endmodule

### rtl/hyq_decode.sv
// Input stage: binary16 to class and fixed-point value; luma takes sample_a only.
`timescale 1ns / 1ps

module hyq_decode import hyq_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic              opcode,
	input  logic [HALF_W-1:0] sample_a,
	input  logic [HALF_W-1:0] sample_b,
	input  logic [HALF_W-1:0] sample_c,
	input  logic [HALF_W-1:0] sample_d,
	output logic              chroma,
	output half_dec_t         dec [4]
);

	half_dec_t dec_s1 [4];
	logic      chroma_s1;
	half_dec_t dec_in [4];
	half_dec_t dec_zero;

	assign dec_zero = '{cls: HC_FIN, mag: '0};

	always_comb begin
		dec_in[0] = decode_half(sample_a);
		// luma ignores the other three samples
		dec_in[1] = opcode ? decode_half(sample_b) : dec_zero;
		dec_in[2] = opcode ? decode_half(sample_c) : dec_zero;
		dec_in[3] = opcode ? decode_half(sample_d) : dec_zero;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1    <= dec_in;
			chroma_s1 <= opcode;
		end
	end

	assign dec    = dec_s1;
	assign chroma = chroma_s1;

endmodule

### rtl/hyq_sum.sv
// Sum stage: exact sum of the block, special-case classification.
`timescale 1ns / 1ps

module hyq_sum import hyq_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic           chroma,
	input  half_dec_t      dec [4],
	output res_cls_t       cls,
	output logic [Q_W-1:0] q
);

	res_cls_t              cls_s2;
	logic [Q_W-1:0]        q_s2;
	res_cls_t              cls_nxt;
	logic signed [SUM_W-1:0] sum;
	logic                  any_nan;
	logic                  pinf;
	logic                  ninf;

	always_comb begin
		any_nan = 1'b0;
		pinf    = 1'b0;
		ninf    = 1'b0;
		for (int i = 0; i < 4; i++) begin
			any_nan = any_nan | (dec[i].cls == HC_NAN);
			pinf    = pinf    | (dec[i].cls == HC_PINF);
			ninf    = ninf    | (dec[i].cls == HC_NINF);
		end
		// luma is scaled by four to share the chroma sum's units
		if (chroma)
			sum = SUM_W'(dec[0].mag) + SUM_W'(dec[1].mag)
			    + SUM_W'(dec[2].mag) + SUM_W'(dec[3].mag);
		else
			sum = SUM_W'(dec[0].mag) <<< 2;

		if (any_nan || (pinf && ninf))
			cls_nxt = RC_ZERO;
		else if (pinf)
			cls_nxt = RC_SAT;
		else if (ninf || sum <= 0)
			cls_nxt = RC_ZERO;
		else
			cls_nxt = RC_CALC;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s2 <= cls_nxt;
			q_s2   <= sum[Q_W-1:0];
		end
	end

	assign cls = cls_s2;
	assign q   = q_s2;

endmodule

### rtl/hyq_mul.sv
// Multiply stage: mean times scale as two registered partial products.
`timescale 1ns / 1ps

module hyq_mul import hyq_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  res_cls_t           cls_in,
	input  logic [Q_W-1:0]     q,
	input  logic [SCALE_W-1:0] scale,
	output res_cls_t           cls,
	output logic [PPLO_W-1:0]  pp_lo,
	output logic [PPHI_W-1:0]  pp_hi
);

	res_cls_t          cls_s3;
	logic [PPLO_W-1:0] pp_lo_s3;
	logic [PPHI_W-1:0] pp_hi_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s3   <= cls_in;
			pp_lo_s3 <= PPLO_W'(q[QLO_W-1:0]) * PPLO_W'(scale);
			pp_hi_s3 <= PPHI_W'(q[Q_W-1:QLO_W]) * PPHI_W'(scale);
		end
	end

	assign cls   = cls_s3;
	assign pp_lo = pp_lo_s3;
	assign pp_hi = pp_hi_s3;

endmodule

### rtl/hyq_round.sv
// Output stage: partial product merge, round half to even, saturate to a byte; forces 0 or 255 by class.
`timescale 1ns / 1ps

module hyq_round import hyq_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  res_cls_t         cls,
	input  logic [PPLO_W-1:0] pp_lo,
	input  logic [PPHI_W-1:0] pp_hi,
	output logic [PIX_W-1:0] pixel_byte
);

	logic [PIX_W-1:0]  pix_s4;
	logic [PIX_W-1:0]  pix_nxt;
	logic [PROD_W-1:0] prod;
	logic [INT_W-1:0]  ip;
	logic              up;
	logic [PIX_W:0]    rnd;

	always_comb begin
		prod = (PROD_W'(pp_hi) << QLO_W) + PROD_W'(pp_lo);
		ip   = prod[PROD_W-1:FRAC_W];
		// above half, or exactly half with an odd integer part
		up   = prod[FRAC_W-1] && ((|prod[FRAC_W-2:0]) || ip[0]);
		rnd  = {1'b0, ip[PIX_W-1:0]} + (PIX_W+1)'(up);
		case (cls)
			RC_SAT:  pix_nxt = '1;
			RC_CALC: begin
				if (ip > INT_W'({PIX_W{1'b1}}) || rnd[PIX_W])
					pix_nxt = '1;
				else
					pix_nxt = rnd[PIX_W-1:0];
			end
			default: pix_nxt = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			pix_s4 <= pix_nxt;
	end

	assign pixel_byte = pix_s4;

endmodule

### rtl/half_to_yuv_pixel_quantizer.sv
// Top level: binary16 to 8-bit pixel quantizer with 2x2 chroma averaging.
`timescale 1ns / 1ps
//
//  port group  | role           | contents
//  ------------+----------------+----------------------------------------------
//  s_*         | input stream   | tdata: sample_a, sample_b, sample_c, sample_d
//              |                | tuser: opcode (0 luma, 1 chroma)
//  m_*         | result stream  | tdata: pixel_byte
//  p*          | APB registers  | 0x0: scale_q16 (Q8.16, bits 23:0)
//
//  One transaction per clock sustained while m_tready is high. The register
//  stages are decode, sum, split multiply (two 21x24 partial products),
//  round and saturate into the output register.
//  Each stage has its own valid bit and moves when the stage after it is empty
//  or moving, so bubbles fill up while m_tready is low and an input is still
//  taken as long as any stage downstream has room.
//  Reset clears the valid bits and loads scale_q16 with 255.0; payload
//  registers are not reset. Write the scale only with the pipeline drained.
//
module half_to_yuv_pixel_quantizer import hyq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [4*HALF_W-1:0] s_tdata,   // [15:0] sample_a, [31:16] sample_b,
	                                       // [47:32] sample_c, [63:48] sample_d
	input  logic [0:0]          s_tuser,   // [0] opcode
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [PIX_W-1:0]    m_tdata,   // [7:0] pixel_byte
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready
);

	logic [SCALE_W-1:0] scale;

	// stage valid bits; v4 is the output register
	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy1, rdy2, rdy3, rdy4;

	logic              chroma;
	half_dec_t         dec [4];
	res_cls_t          cls_sum;
	logic [Q_W-1:0]    q;
	res_cls_t          cls_mul;
	logic [PPLO_W-1:0] pp_lo;
	logic [PPHI_W-1:0] pp_hi;

	// a stage can load when it is empty or its content moves on this cycle
	assign rdy4     = !v4_q || m_tready;
	assign rdy3     = !v3_q || rdy4;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = v4_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= s_tvalid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
		end
	end

	hyq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.scale   (scale)
	);

	hyq_decode u_decode (
		.clk      (clk),
		.en       (rdy1),
		.opcode   (s_tuser[0]),
		.sample_a (s_tdata[HALF_W-1:0]),
		.sample_b (s_tdata[2*HALF_W-1:HALF_W]),
		.sample_c (s_tdata[3*HALF_W-1:2*HALF_W]),
		.sample_d (s_tdata[4*HALF_W-1:3*HALF_W]),
		.chroma   (chroma),
		.dec      (dec)
	);

	hyq_sum u_sum (
		.clk    (clk),
		.en     (rdy2),
		.chroma (chroma),
		.dec    (dec),
		.cls    (cls_sum),
		.q      (q)
	);

	hyq_mul u_mul (
		.clk    (clk),
		.en     (rdy3),
		.cls_in (cls_sum),
		.q      (q),
		.scale  (scale),
		.cls    (cls_mul),
		.pp_lo  (pp_lo),
		.pp_hi  (pp_hi)
	);

	hyq_round u_round (
		.clk        (clk),
		.en         (rdy4),
		.cls        (cls_mul),
		.pp_lo      (pp_lo),
		.pp_hi      (pp_hi),
		.pixel_byte (m_tdata)
	);

endmodule
